>>> hw/rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types for the swept box collision block.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int AXIS_W = 2;
  localparam int TIME_W = 17;
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic             hit;
    logic [TIME_W-1:0] time_res;
    logic [1:0]       normal_x;
    logic [1:0]       normal_y;
    logic [1:0]       normal_z;
  } result_t;

endpackage

>>> hw/rtl/sbc_front.sv
// ----------------------------------------------------------------------------
// sbc_front
// Accepts axis beats, forms the slab numerators and queues them for the back.
// Two-entry queue.
// ----------------------------------------------------------------------------
module sbc_front #(
  parameter int CW = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_axis,
  input  logic [CW-1:0]       in_mmin,
  input  logic [CW-1:0]       in_mmax,
  input  logic [CW-1:0]       in_vel,
  input  logic [CW-1:0]       in_bmin,
  input  logic [CW-1:0]       in_bmax,
  input  logic                in_last,
  output logic                q_valid,
  input  logic                q_ready,
  output logic [1:0]          q_axis,
  output logic signed [CW:0]  q_num_in,
  output logic signed [CW:0]  q_num_out,
  output logic signed [CW-1:0] q_vel,
  output logic                q_last
);
  import sbc_pkg::*;

  localparam int EW = 2 + 2 * (CW + 1) + CW + 1;

  logic [EW-1:0] mem [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic [EW-1:0] wdata;
  logic signed [CW:0] ni;
  logic signed [CW:0] no;
  logic          push;
  logic          pop;

  assign ni = $signed({in_bmin[CW-1], in_bmin}) - $signed({in_mmax[CW-1], in_mmax});
  assign no = $signed({in_bmax[CW-1], in_bmax}) - $signed({in_mmin[CW-1], in_mmin});
  assign wdata = {in_axis, ni, no, in_vel, in_last};
  assign in_ready = (cnt != 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  assign {q_axis, q_num_in, q_num_out, q_vel, q_last} = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) (cnt == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (cnt == $past(cnt) + 2'd1))
    else $error("queue count slip");

endmodule

>>> hw/rtl/sbc_div.sv
// ----------------------------------------------------------------------------
// sbc_div
// Restoring divider, one quotient bit per cycle, both slab quotients in
// parallel, magnitude saturated at 2^(CW-1)-1.
// ----------------------------------------------------------------------------
module sbc_div #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [CW:0]   num_a,
  input  logic signed [CW:0]   num_b,
  input  logic signed [CW-1:0] den,
  output logic                 done,
  output logic signed [CW:0]   quo_a,
  output logic signed [CW:0]   quo_b
);
  import sbc_pkg::*;

  localparam int NW = CW + 1 + FB;
  localparam int CNTW = $clog2(NW + 1);
  localparam logic [CW:0] LIM = {2'b00, {(CW-1){1'b1}}};

  div_state_t st;
  div_state_t st_next;
  logic [NW-1:0] na, nb;
  logic [NW:0]   ra, rb;
  logic [NW-1:0] qa, qb;
  logic [CW-1:0] d;
  logic          nega, negb;
  logic [CNTW-1:0] cnt;
  logic [NW:0]   ta, tb;
  logic [CW:0]   ma, mb;
  logic [CW:0]   absa, absb;
  logic [CW-1:0] absd;

  assign absa = num_a[CW] ? (~num_a + 1'b1) : num_a;
  assign absb = num_b[CW] ? (~num_b + 1'b1) : num_b;
  assign absd = den[CW-1] ? (~den + 1'b1) : den;
  assign ta = {ra[NW-1:0], na[NW-1]};
  assign tb = {rb[NW-1:0], nb[NW-1]};

  always_comb begin
    st_next = st;
    case (st)
      DIV_IDLE: if (start) st_next = DIV_RUN;
      DIV_RUN:  if (cnt == CNTW'(NW - 1)) st_next = DIV_DONE;
      DIV_DONE: st_next = DIV_IDLE;
      default:  st_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    done = (st == DIV_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) st <= DIV_IDLE;
    else st <= st_next;
  end

  always_ff @(posedge clk) begin
    case (st)
      DIV_IDLE: begin
        na <= {absa, {FB{1'b0}}};
        nb <= {absb, {FB{1'b0}}};
        ra <= '0;
        rb <= '0;
        qa <= '0;
        qb <= '0;
        d <= absd;
        nega <= num_a[CW] ^ den[CW-1];
        negb <= num_b[CW] ^ den[CW-1];
        cnt <= '0;
      end
      DIV_RUN: begin
        na <= na << 1;
        nb <= nb << 1;
        cnt <= cnt + 1'b1;
        if (ta >= {{(NW+1-CW){1'b0}}, d}) begin
          ra <= ta - {{(NW+1-CW){1'b0}}, d};
          qa <= {qa[NW-2:0], 1'b1};
        end else begin
          ra <= ta;
          qa <= {qa[NW-2:0], 1'b0};
        end
        if (tb >= {{(NW+1-CW){1'b0}}, d}) begin
          rb <= tb - {{(NW+1-CW){1'b0}}, d};
          qb <= {qb[NW-2:0], 1'b1};
        end else begin
          rb <= tb;
          qb <= {qb[NW-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  assign ma = (qa > NW'(LIM)) ? LIM : qa[CW:0];
  assign mb = (qb > NW'(LIM)) ? LIM : qb[CW:0];
  assign quo_a = nega ? $signed(~ma + 1'b1) : $signed(ma);
  assign quo_b = negb ? $signed(~mb + 1'b1) : $signed(mb);

  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  assert property (@(posedge clk) disable iff (rst) done |-> !quo_a[CW-1] || quo_a[CW])
    else $error("quotient beyond saturation");

endmodule

>>> hw/rtl/sbc_back.sv
// ----------------------------------------------------------------------------
// sbc_back
// Divides each queued axis with nonzero velocity, folds entry/exit times and
// emits the result on the last axis through an output register.
// ----------------------------------------------------------------------------
module sbc_back #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [1:0]            q_axis,
  input  logic signed [CW:0]    q_num_in,
  input  logic signed [CW:0]    q_num_out,
  input  logic signed [CW-1:0]  q_vel,
  input  logic                  q_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sbc_pkg::result_t      out_res
);
  import sbc_pkg::*;

  localparam logic signed [CW:0] ONE = (CW+1)'(1) <<< FB;

  logic busy;
  logic start;
  logic done;
  logic signed [CW:0] t1, t2, lo, hi;
  logic signed [CW:0] entry_best, exit_best;
  logic [1:0] normal_axis;
  logic normal_positive;
  logic rejected;
  logic signed [CW:0] e_next, x_next;
  logic [1:0] na_next;
  logic np_next, rj_next;
  logic fin;
  logic fire;
  logic hit;
  logic [1:0] nv;
  logic [1:0] nbase;
  logic zvel;

  assign zvel = (q_vel == '0);
  assign fin = q_valid && !out_valid && (zvel ? !busy : done);
  assign start = q_valid && !busy && !zvel && !out_valid;
  assign q_ready = fin;
  assign fire = fin;

  sbc_div #(.CW(CW), .FB(FB)) u_div (
    .clk(clk), .rst(rst), .start(start),
    .num_a(q_num_in), .num_b(q_num_out), .den(q_vel),
    .done(done), .quo_a(t1), .quo_b(t2)
  );

  always_comb begin
    e_next = entry_best;
    x_next = exit_best;
    na_next = normal_axis;
    np_next = normal_positive;
    rj_next = rejected;
    lo = (t1 > t2) ? t2 : t1;
    hi = (t1 > t2) ? t1 : t2;
    if (zvel) begin
      if (q_num_in > 0 || q_num_out < 0) rj_next = 1'b1;
    end else begin
      if (lo > entry_best) begin
        e_next = lo;
        na_next = q_axis;
        np_next = (t1 > t2);
      end
      if (hi < exit_best) x_next = hi;
    end
    hit = !rj_next && (e_next <= x_next) && (e_next >= 0) && (e_next < ONE);
    nbase = np_next ? 2'b01 : 2'b11;
    nv = hit ? nbase : 2'b00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      entry_best <= '0;
      exit_best <= ONE;
      normal_axis <= AXIS_NONE;
      normal_positive <= 1'b0;
      rejected <= 1'b0;
    end else begin
      if (start) busy <= 1'b1;
      else if (done) busy <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (fire) begin
        if (q_last) begin
          out_valid <= 1'b1;
          entry_best <= '0;
          exit_best <= ONE;
          normal_axis <= AXIS_NONE;
          normal_positive <= 1'b0;
          rejected <= 1'b0;
        end else begin
          entry_best <= e_next;
          exit_best <= x_next;
          normal_axis <= na_next;
          normal_positive <= np_next;
          rejected <= rj_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && q_last) begin
      out_res.hit <= hit;
      out_res.time_res <= hit ? TIME_W'(e_next) : TIME_W'(ONE);
      out_res.normal_x <= (na_next == 2'd0) ? nv : 2'b00;
      out_res.normal_y <= (na_next == 2'd1) ? nv : 2'b00;
      out_res.normal_z <= (na_next == 2'd2) ? nv : 2'b00;
    end
  end

  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) exit_best <= ONE)
    else $error("exit above one");
  assert property (@(posedge clk) disable iff (rst) q_ready |-> !out_valid)
    else $error("fold over pending result");

endmodule

>>> hw/rtl/swept_box_collision.sv
// ----------------------------------------------------------------------------
// swept_box_collision
// Swept box slab test: front queue, divider-driven fold, registered result.
// ----------------------------------------------------------------------------
// A nonzero-velocity axis passes the queue, then the divider (IDLE, RUN, DONE), and
// folds; a zero-velocity axis folds straight from the queue. The last axis's result
// beat is valid right after its fold. The shared bit-serial divider takes one axis
// at a time and finishes it before the next starts; zero-velocity axes fold one per
// cycle while it is idle and no result beat is pending. A result beat held by
// m_tready stalls the fold. Reset (rst, synchronous) clears queue and fold state.
module swept_box_collision #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // axis, moving_min, moving_max, velocity, box_min, box_max (low to high)
  input  logic [((2 + 5 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // hit, time_res, normal_x, normal_y, normal_z (low to high)
  output logic [23:0] m_tdata
);
  import sbc_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic q_valid, q_ready, q_last;
  logic [1:0] q_axis;
  logic signed [CW:0] q_num_in, q_num_out;
  logic signed [CW-1:0] q_vel;
  result_t res;

  sbc_front #(.CW(CW)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_axis(s_tdata[1:0]),
    .in_mmin(s_tdata[2 +: CW]),
    .in_mmax(s_tdata[2 + CW +: CW]),
    .in_vel(s_tdata[2 + 2 * CW +: CW]),
    .in_bmin(s_tdata[2 + 3 * CW +: CW]),
    .in_bmax(s_tdata[2 + 4 * CW +: CW]),
    .in_last(s_tlast),
    .q_valid(q_valid), .q_ready(q_ready),
    .q_axis(q_axis), .q_num_in(q_num_in), .q_num_out(q_num_out),
    .q_vel(q_vel), .q_last(q_last)
  );

  sbc_back #(.CW(CW), .FB(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready),
    .q_axis(q_axis), .q_num_in(q_num_in), .q_num_out(q_num_out),
    .q_vel(q_vel), .q_last(q_last),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tdata = {res.normal_z, res.normal_y, res.normal_x, res.time_res, res.hit};

endmodule
